FILE: hw/rtl/text_terminal_writer_defines.svh
// assertion macros shared by the text terminal writer rtl
// needs clk and rst_n in scope at the point of use
`ifndef TEXT_TERMINAL_WRITER_DEFINES_SVH
`define TEXT_TERMINAL_WRITER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define TTW_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define TTW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/ttw_pkg.sv
// shared types and constants of the text terminal writer
// no dependencies
package ttw_pkg;

    // request codes
    localparam logic [1:0] REQ_PUT      = 2'd0;
    localparam logic [1:0] REQ_SET_ATTR = 2'd1;
    localparam logic [1:0] REQ_READ     = 2'd2;

    // control bytes
    localparam logic [7:0] CODE_TAB     = 8'd9;
    localparam logic [7:0] CODE_NEWLINE = 8'd10;
    localparam logic [7:0] CODE_RETURN  = 8'd13;
    localparam logic [7:0] CODE_SPACE   = 8'd32;

    // white on black
    localparam logic [7:0] RESET_ATTRIBUTE = 8'd15;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [7:0]  char_code;
        logic [7:0]  attribute_value;
        logic [10:0] cell_index;
        logic        end_of_string;
    } in_item_t;

    typedef struct packed {
        logic [6:0] cursor_col;
        logic [4:0] cursor_row;
        logic [7:0] read_char;
        logic [7:0] read_attribute;
        logic       write_done;
    } out_item_t;

    typedef struct packed {
        logic idle;
        logic resp_load;
    } ttw_status_t;

endpackage

FILE: hw/rtl/ttw_screen_mem.sv
// character store of the screen, one write and one registered read port
// no dependencies
module ttw_screen_mem #(
    parameter int DEPTH = 2000,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);

    logic [7:0] cells_mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            cells_mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= cells_mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/ttw_ctrl.sv
// request sequencer: cursor, circular row mapping, tab and scroll handling
// depends on ttw_pkg and text_terminal_writer_defines.svh
`include "text_terminal_writer_defines.svh"

module ttw_ctrl #(
    parameter int COLUMNS  = 80,
    parameter int ROWS     = 25,
    parameter int TAB_STOP = 4,
    localparam int CELLS   = COLUMNS * ROWS,
    localparam int AW      = $clog2(CELLS)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_accept,
    input  ttw_pkg::in_item_t   in_data,
    input  logic                slot_free,
    output ttw_pkg::ttw_status_t status,
    output ttw_pkg::out_item_t  resp,
    output logic                mem_we,
    output logic [AW-1:0]       mem_waddr,
    output logic [7:0]          mem_wdata,
    output logic                mem_re,
    output logic [AW-1:0]       mem_raddr,
    input  logic [7:0]          mem_rdata
);

    import ttw_pkg::*;

    localparam int COL_W = $clog2(COLUMNS);
    localparam int ROW_W = $clog2(ROWS);
    localparam int GW    = $clog2(COLUMNS + 1);
    localparam int TW    = (TAB_STOP > 1) ? $clog2(TAB_STOP) : 1;
    localparam int IW    = ((AW > 11) ? AW : 11) + 1;

    localparam logic [AW:0] CELLS_X = (AW + 1)'(CELLS);
    localparam logic [AW:0] COLS_X  = (AW + 1)'(COLUMNS);

    typedef enum logic [5:0] {
        ST_CLEAR  = 6'b000001,
        ST_IDLE   = 6'b000010,
        ST_PUT    = 6'b000100,
        ST_SCROLL = 6'b001000,
        ST_RADDR  = 6'b010000,
        ST_RESP   = 6'b100000
    } state_t;

    // start of the physical row that follows, wrapping round the store
    function automatic logic [AW-1:0] row_step(input logic [AW-1:0] a);
        logic [AW:0] s;
        s = {1'b0, a} + COLS_X;
        if (s >= CELLS_X)
        begin
            s = s - CELLS_X;
        end
        return s[AW-1:0];
    endfunction

    state_t           state_reg, state_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] line_reg, line_next;
    logic [AW-1:0]    base_reg, base_next;   // physical start of cursor line
    logic [AW-1:0]    top_reg, top_next;     // physical start of screen row 0
    logic [7:0]       attr_reg, attr_next;
    logic [TW-1:0]    phase_reg, phase_next; // column modulo tab stop
    logic [GW-1:0]    guard_reg, guard_next;
    logic             more_reg, more_next;
    logic [AW-1:0]    clr_reg, clr_next;
    logic             inr_reg, inr_next;
    in_item_t         req_reg;

    logic             is_tab, is_nl, is_cr, places;
    logic             col_last, line_last, line_adv;
    logic [TW-1:0]    phase_step, phase_after;
    logic [GW-1:0]    guard_step;
    logic             tab_more;
    logic [IW-1:0]    idx_x, rsum, rfix;
    logic             in_range;

    assign is_tab   = req_reg.char_code == CODE_TAB;
    assign is_nl    = req_reg.char_code == CODE_NEWLINE;
    assign is_cr    = req_reg.char_code == CODE_RETURN;
    assign places   = !is_nl && !is_cr;
    assign col_last = col_reg == COL_W'(COLUMNS - 1);
    assign line_last = line_reg == ROW_W'(ROWS - 1);
    assign line_adv = (places && col_last) || is_nl;

    assign phase_step  = (phase_reg == TW'(TAB_STOP - 1)) ? '0 : phase_reg + TW'(1);
    assign phase_after = (places && !col_last) ? phase_step : '0;
    assign guard_step  = guard_reg + GW'(1);
    assign tab_more    = is_tab && (phase_after != '0) && (guard_step != GW'(COLUMNS));

    // logical cell index to physical address
    assign idx_x     = IW'(req_reg.cell_index);
    assign in_range  = idx_x < IW'(CELLS);
    assign rsum      = IW'(top_reg) + idx_x;
    assign rfix      = (rsum >= IW'(CELLS)) ? rsum - IW'(CELLS) : rsum;
    assign mem_raddr = rfix[AW-1:0];

    always_comb
    begin
        state_next = state_reg;
        col_next   = col_reg;
        line_next  = line_reg;
        base_next  = base_reg;
        top_next   = top_reg;
        attr_next  = attr_reg;
        phase_next = phase_reg;
        guard_next = guard_reg;
        more_next  = more_reg;
        clr_next   = clr_reg;
        inr_next   = inr_reg;
        mem_we     = 1'b0;
        mem_waddr  = clr_reg;
        mem_wdata  = '0;
        mem_re     = 1'b0;
        status     = '0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we   = 1'b1;
                clr_next = clr_reg + AW'(1);
                if (clr_reg == AW'(CELLS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                status.idle = 1'b1;
                if (in_accept)
                begin
                    guard_next = '0;
                    unique case (in_data.req_type)
                        REQ_PUT:      state_next = ST_PUT;
                        REQ_READ:     state_next = ST_RADDR;
                        REQ_SET_ATTR:
                        begin
                            attr_next  = in_data.attribute_value;
                            state_next = ST_RESP;
                        end
                        default:      state_next = ST_RESP;
                    endcase
                end
            end
            ST_PUT:
            begin
                mem_we     = places;
                mem_waddr  = base_reg + AW'(col_reg);
                mem_wdata  = is_tab ? CODE_SPACE : req_reg.char_code;
                phase_next = phase_after;
                guard_next = guard_step;
                more_next  = tab_more;
                if (places && !col_last)
                begin
                    col_next = col_reg + COL_W'(1);
                end
                else
                begin
                    col_next = '0;
                end
                if (line_adv)
                begin
                    // on a scroll, the new bottom row reuses the old top row
                    base_next = row_step(base_reg);
                    if (line_last)
                    begin
                        top_next = row_step(top_reg);
                    end
                    else
                    begin
                        line_next = line_reg + ROW_W'(1);
                    end
                end
                clr_next = '0;
                if (line_adv && line_last)
                begin
                    state_next = ST_SCROLL;
                end
                else if (tab_more)
                begin
                    state_next = ST_PUT;
                end
                else
                begin
                    state_next = ST_RESP;
                end
            end
            ST_SCROLL:
            begin
                mem_we    = 1'b1;
                mem_waddr = base_reg + clr_reg;
                clr_next  = clr_reg + AW'(1);
                if (clr_reg == AW'(COLUMNS - 1))
                begin
                    state_next = more_reg ? ST_PUT : ST_RESP;
                end
            end
            ST_RADDR:
            begin
                mem_re     = in_range;
                inr_next   = in_range;
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                status.resp_load = slot_free;
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // every cell's attribute always equals the current attribute, so only
    // characters are stored
    always_comb
    begin
        resp.cursor_col     = 7'(col_reg);
        resp.cursor_row     = 5'(line_reg);
        resp.write_done     = req_reg.end_of_string;
        resp.read_char      = '0;
        resp.read_attribute = '0;
        if (req_reg.req_type == REQ_READ && inr_reg)
        begin
            resp.read_char      = mem_rdata;
            resp.read_attribute = attr_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            col_reg   <= '0;
            line_reg  <= '0;
            base_reg  <= '0;
            top_reg   <= '0;
            attr_reg  <= RESET_ATTRIBUTE;
            phase_reg <= '0;
            guard_reg <= '0;
            more_reg  <= 1'b0;
            clr_reg   <= '0;
            inr_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            col_reg   <= col_next;
            line_reg  <= line_next;
            base_reg  <= base_next;
            top_reg   <= top_next;
            attr_reg  <= attr_next;
            phase_reg <= phase_next;
            guard_reg <= guard_next;
            more_reg  <= more_next;
            clr_reg   <= clr_next;
            inr_reg   <= inr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept && state_reg == ST_IDLE)
        begin
            req_reg <= in_data;
        end
    end

    `TTW_ASSERT_NOW(a_cursor_range, 1'b1,
        (32'(col_reg) < COLUMNS) && (32'(line_reg) < ROWS), "cursor out of range")
    `TTW_ASSERT_NOW(a_rows_range, 1'b1,
        (32'(base_reg) < CELLS) && (32'(top_reg) < CELLS), "row start out of store")
    `TTW_ASSERT_NOW(a_write_state, mem_we,
        state_reg == ST_CLEAR || state_reg == ST_SCROLL || state_reg == ST_PUT,
        "store written outside a writing state")
    `TTW_ASSERT_NOW(a_scroll_count, state_reg == ST_SCROLL,
        32'(clr_reg) < COLUMNS, "row clear ran past the row")

endmodule

FILE: hw/rtl/text_terminal_writer.sv
// text terminal writer: request channel in, one result per request out
//
// requests arrive on in_valid/in_ready with in_data; results leave on
// out_valid/out_ready with out_data, one result for every request, in order
// an ordinary character or control byte passes through the put state, then the
// result state; a tab stays in the put state for each space placed (up to the tab stop)
// a scroll adds a clear of the new bottom row, one store write per cell of that row
// read: address, store read, result; set attribute goes straight to the result state
// one request is worked at a time; the single-port write of the character
// store sets the per-character and per-scroll cost
// after reset every cell of the store is swept to character 0, with in_ready
// low; the cursor starts at the top left, attribute 15
// the result register lets the next request be taken while a result still
// waits; a request finishing while the receiver stalls waits for the slot
// depends on ttw_pkg, ttw_ctrl, ttw_screen_mem and text_terminal_writer_defines.svh
`include "text_terminal_writer_defines.svh"

module text_terminal_writer #(
    parameter int COLUMNS  = 80,
    parameter int ROWS     = 25,
    parameter int TAB_STOP = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  ttw_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output ttw_pkg::out_item_t out_data
);

    import ttw_pkg::*;

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);

    ttw_status_t   status;
    out_item_t     resp;
    logic          in_accept;
    logic          slot_free;

    // store port
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    logic [7:0]    mem_rdata;

    // result register
    logic          out_valid_reg, out_valid_next;
    out_item_t     out_data_reg;

    assign in_ready  = status.idle;
    assign in_accept = in_valid && in_ready;
    // slot is free when empty or being emptied this cycle
    assign slot_free = !out_valid_reg || out_ready;

    ttw_ctrl #(
        .COLUMNS  (COLUMNS),
        .ROWS     (ROWS),
        .TAB_STOP (TAB_STOP)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_accept (in_accept),
        .in_data   (in_data),
        .slot_free (slot_free),
        .status    (status),
        .resp      (resp),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    ttw_screen_mem #(
        .DEPTH (CELLS)
    ) u_screen_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (status.resp_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (status.resp_load)
        begin
            out_data_reg <= resp;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `TTW_ASSERT_NOW(a_no_overwrite, status.resp_load,
        !out_valid_reg || out_ready, "result register overwritten")
    `TTW_ASSERT_NEXT(a_accept_busy, in_accept,
        !status.idle, "accepted request left the sequencer idle")
    `TTW_ASSERT_NOW(a_rise_from_load, $rose(out_valid_reg),
        $past(status.resp_load), "result appeared without a load")

endmodule

FILE: bench/text_terminal_writer_tb.sv
// self-checking bench for the text terminal writer: drives put, set-attribute and
// read requests, predicts every result and compares it field by field
// depends on ttw_pkg and the text_terminal_writer rtl
module text_terminal_writer_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import ttw_pkg::*;

    // screen geometry, kept equal to the instance parameters
    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int TAB_STOP   = 4;
    localparam int CELL_COUNT = COLUMNS * ROWS;

    // request code the block leaves unused
    localparam logic [1:0] REQ_NONE = 2'd3;

    // run bounds: store sweep after reset, scroll cost, stalls and gaps, several times over
    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE_CYCLES = 200;
    localparam int CALM_ITEMS = 150;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    in_item_t  in_data = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_item_t out_data;

    text_terminal_writer #(
        .COLUMNS  (COLUMNS),
        .ROWS     (ROWS),
        .TAB_STOP (TAB_STOP)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // 12 ns period
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // requests waiting to be driven, and results still owed by the block
    in_item_t  pending_reqs[$];
    out_item_t results_due[$];

    int req_pushed_cnt = 0;
    int req_issue_cnt = 0;
    int req_accept_cnt = 0;
    int error_count = 0;
    int cycle_count = 0;
    bit calm_tail = 1'b0;

    // shadow copy of the terminal: screen store, cursor and current attribute
    logic [7:0] shadow_char [CELL_COUNT];
    logic [7:0] shadow_attr [CELL_COUNT];
    int         cur_col;
    int         cur_row;
    logic [7:0] cur_attr;

    task automatic flag_mismatch(input string what, input int got, input int want);
        error_count++;
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    endtask

    task automatic clear_shadow();
        for (int i = 0; i < CELL_COUNT; i++)
        begin
            shadow_char[i] = 8'd0;
            shadow_attr[i] = RESET_ATTRIBUTE;
        end
        cur_col = 0;
        cur_row = 0;
        cur_attr = RESET_ATTRIBUTE;
    endtask

    // wrap at the right edge, scroll up one row past the bottom
    function automatic void settle_cursor();
        if (cur_col >= COLUMNS)
        begin
            cur_row++;
            cur_col = 0;
        end
        if (cur_row >= ROWS)
        begin
            for (int i = 0; i < CELL_COUNT - COLUMNS; i++)
            begin
                shadow_char[i] = shadow_char[i + COLUMNS];
                shadow_attr[i] = shadow_attr[i + COLUMNS];
            end
            // new bottom row: character 0 with the current attribute
            for (int i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++)
            begin
                shadow_char[i] = 8'd0;
                shadow_attr[i] = cur_attr;
            end
            cur_row = ROWS - 1;
        end
    endfunction

    function automatic void place_glyph(input logic [7:0] code);
        int pos;
        pos = cur_row * COLUMNS + cur_col;
        if (pos < CELL_COUNT)
        begin
            shadow_char[pos] = code;
            shadow_attr[pos] = cur_attr;
        end
        cur_col++;
        settle_cursor();
    endfunction

    // works one request on the shadow terminal and returns the result it owes
    function automatic out_item_t terminal_response(input in_item_t r);
        out_item_t res;
        int        spaces;
        res = '0;
        case (r.req_type)
            REQ_PUT:
            begin
                if (r.char_code == CODE_NEWLINE)
                begin
                    cur_row++;
                    cur_col = 0;
                    settle_cursor();
                end
                else if (r.char_code == CODE_RETURN)
                    cur_col = 0;
                else if (r.char_code == CODE_TAB)
                begin
                    // at least one space, then on to the next tab stop
                    spaces = 0;
                    do
                    begin
                        place_glyph(CODE_SPACE);
                        spaces++;
                    end
                    while ((cur_col % TAB_STOP) != 0 && spaces < COLUMNS);
                end
                else
                    place_glyph(r.char_code);
            end
            REQ_SET_ATTR:
            begin
                cur_attr = r.attribute_value;
                for (int i = 0; i < CELL_COUNT; i++)
                    shadow_attr[i] = r.attribute_value;
            end
            REQ_READ:
            begin
                // beyond the last cell reads back as zero
                if (r.cell_index < CELL_COUNT)
                begin
                    res.read_char = shadow_char[r.cell_index];
                    res.read_attribute = shadow_attr[r.cell_index];
                end
            end
            default: ;
        endcase
        res.cursor_col = 7'(cur_col);
        res.cursor_row = 5'(cur_row);
        res.write_done = r.end_of_string;
        return res;
    endfunction

    // request with every field random, so ignored fields still toggle
    function automatic in_item_t noise_req();
        in_item_t r;
        r.req_type = 2'($urandom_range(0, 3));
        r.char_code = 8'($urandom_range(0, 255));
        r.attribute_value = 8'($urandom_range(0, 255));
        r.cell_index = 11'($urandom_range(0, 2047));
        r.end_of_string = 1'($urandom_range(0, 1));
        return r;
    endfunction

    task automatic push_req(input in_item_t r);
        pending_reqs.push_back(r);
        req_pushed_cnt++;
    endtask

    task automatic push_put(input logic [7:0] code, input logic eos);
        in_item_t r;
        r = noise_req();
        r.req_type = REQ_PUT;
        r.char_code = code;
        r.end_of_string = eos;
        push_req(r);
    endtask

    task automatic push_set_attr(input logic [7:0] attr);
        in_item_t r;
        r = noise_req();
        r.req_type = REQ_SET_ATTR;
        r.attribute_value = attr;
        push_req(r);
    endtask

    task automatic push_read(input int idx);
        in_item_t r;
        r = noise_req();
        r.req_type = REQ_READ;
        r.cell_index = 11'(idx);
        push_req(r);
    endtask

    // mostly printable text with the odd control byte mixed in
    function automatic logic [7:0] text_byte(input bit plain);
        int pick;
        pick = $urandom_range(0, 99);
        if (plain || pick < 62)
            return 8'($urandom_range(32, 126));
        else if (pick < 72)
            return 8'($urandom_range(0, 255));
        else if (pick < 82)
            return CODE_NEWLINE;
        else if (pick < 88)
            return CODE_TAB;
        else if (pick < 93)
            return CODE_RETURN;
        return 8'($urandom_range(0, 31));
    endfunction

    // write calls, newline runs, reads, attribute changes and noise
    task automatic queue_traffic(input int count);
        int target;
        int len;
        int pick;
        bit plain;
        target = req_pushed_cnt + count;
        while (req_pushed_cnt < target)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
            begin
                // long plain lines push the cursor over the right edge
                plain = ($urandom_range(0, 9) == 0);
                len = plain ? $urandom_range(60, 120) : $urandom_range(1, 30);
                for (int i = 0; i < len; i++)
                    push_put(text_byte(plain), i == len - 1);
            end
            else if (pick < 65)
            begin
                // run of newlines to reach the bottom row and scroll
                len = $urandom_range(5, 30);
                for (int i = 0; i < len; i++)
                    push_put(CODE_NEWLINE, i == len - 1);
            end
            else if (pick < 80)
                push_read(($urandom_range(0, 7) == 0) ? $urandom_range(CELL_COUNT, 2047)
                                                      : $urandom_range(0, CELL_COUNT - 1));
            else if (pick < 85)
                push_set_attr(8'($urandom_range(0, 255)));
            else if (pick < 90)
            begin
                push_req(noise_req());
                pending_reqs[$].req_type = REQ_NONE;
            end
            else
                push_req(noise_req());
        end
    endtask

    // block until every queued request is taken and every result is back
    task automatic wait_drained();
        while (req_accept_cnt != req_pushed_cnt || results_due.size() != 0)
            @(negedge clk);
    endtask

    // request driver: holds a request until taken, then idles or loads the next
    int gap_left = 0;

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && req_accept_cnt != req_issue_cnt)
                ;   // still waiting for the handshake
            else if (gap_left > 0)
            begin
                in_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (!calm_tail && pending_reqs.size() != 0 && $urandom_range(0, 5) == 0)
            begin
                in_valid <= 1'b0;
                gap_left <= $urandom_range(0, 6);
            end
            else if (pending_reqs.size() != 0)
            begin
                in_valid <= 1'b1;
                in_data <= pending_reqs.pop_front();
                req_issue_cnt <= req_issue_cnt + 1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // result receiver: random stall bursts, none in the closing stretch
    int stall_left = 0;

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left <= stall_left - 1;
            end
            else if (!calm_tail && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                stall_left <= $urandom_range(0, 6);
            end
            else
                out_ready <= 1'b1;
        end
    end

    // monitor: checks finished results first, then predicts for the newly taken request
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (results_due.size() == 0)
                    flag_mismatch("result with no request outstanding, cursor_col",
                                  int'(out_data.cursor_col), 0);
                else
                begin
                    want = results_due.pop_front();
                    if (out_data.cursor_col !== want.cursor_col)
                        flag_mismatch("cursor_col", int'(out_data.cursor_col),
                                      int'(want.cursor_col));
                    if (out_data.cursor_row !== want.cursor_row)
                        flag_mismatch("cursor_row", int'(out_data.cursor_row),
                                      int'(want.cursor_row));
                    if (out_data.read_char !== want.read_char)
                        flag_mismatch("read_char", int'(out_data.read_char),
                                      int'(want.read_char));
                    if (out_data.read_attribute !== want.read_attribute)
                        flag_mismatch("read_attribute", int'(out_data.read_attribute),
                                      int'(want.read_attribute));
                    if (out_data.write_done !== want.write_done)
                        flag_mismatch("write_done", int'(out_data.write_done),
                                      int'(want.write_done));
                end
            end
            if (in_valid && in_ready)
            begin
                results_due.push_back(terminal_response(in_data));
                req_accept_cnt++;
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        clear_shadow();
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        // directed: reset contents, store edges, out-of-range reads
        push_read(0);
        push_read(CELL_COUNT - 1);
        push_read(CELL_COUNT);
        push_read(2047);
        // byte extremes and ordinary text
        push_put(8'h00, 1'b0);
        push_put(8'hFF, 1'b1);
        push_put(8'h41, 1'b0);
        // tab from column 3 puts one space, from a tab stop a full four
        push_put(CODE_TAB, 1'b0);
        push_put(CODE_TAB, 1'b0);
        push_put(8'h7A, 1'b0);
        push_put(CODE_RETURN, 1'b0);
        push_put(CODE_NEWLINE, 1'b1);
        push_put(8'h42, 1'b1);
        push_read(0);
        push_read(COLUMNS);
        // attribute extremes rewrite every cell
        push_set_attr(8'h00);
        push_read(1);
        push_set_attr(8'hFF);
        push_read(COLUMNS);
        push_read(CELL_COUNT - 1);
        // unused request code with every field at its top
        push_req('1);
        pending_reqs[$].req_type = REQ_NONE;
        push_set_attr(RESET_ATTRIBUTE);
        wait_drained();

        queue_traffic(550);
        // hold the sender back until everything is answered
        wait_drained();
        queue_traffic(500);
        wait (pending_reqs.size() < 20);
        // closing stretch without idling on either side
        calm_tail = 1'b1;
        queue_traffic(CALM_ITEMS);
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);

        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
